### design/apev_pkg.sv
// Shared types and constants for the APEv2 tag item parser.
// No dependencies; every other design file imports this package.
package apev_pkg;

  // Field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CLASS_W     = 3;
  localparam int unsigned INDEX_W     = 20;
  localparam int unsigned REGION_W    = 31;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 31;

  typedef logic [CLASS_W-1:0] byte_class_t;
  typedef logic [1:0]         phase_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 1'd1;

  // Parse phases
  localparam phase_t PH_LEN   = 2'd0;
  localparam phase_t PH_FLAGS = 2'd1;
  localparam phase_t PH_KEY   = 2'd2;
  localparam phase_t PH_VALUE = 2'd3;

  // Byte classes
  localparam byte_class_t CL_LEN   = 3'd0;
  localparam byte_class_t CL_FLAG  = 3'd1;
  localparam byte_class_t CL_KEY   = 3'd2;
  localparam byte_class_t CL_TERM  = 3'd3;
  localparam byte_class_t CL_VALUE = 3'd4;
  localparam byte_class_t CL_IGN   = 3'd5;

  // Item type bits in the first flag byte
  localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h06;

  // One result word
  typedef struct packed {
    byte_class_t         byte_class;
    logic [BYTE_W-1:0]   out_byte;
    logic                item_is_text;
    logic                item_end;
    logic [INDEX_W-1:0]  item_index;
    logic                parse_error;
  } result_t;

endpackage

### design/apev_stream_if.sv
// Valid/ready channel interfaces for the APEv2 tag item parser.
// Depends on apev_pkg for field widths and the byte class type.
interface apev_in_if import apev_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface apev_out_if import apev_pkg::*; ();
  logic               valid;
  logic               ready;
  byte_class_t        byte_class;
  logic [BYTE_W-1:0]  out_byte;
  logic               item_is_text;
  logic               item_end;
  logic [INDEX_W-1:0] item_index;
  logic               parse_error;

  modport source (output valid, output byte_class, output out_byte, output item_is_text,
                  output item_end, output item_index, output parse_error, input ready);
  modport sink   (input valid, input byte_class, input out_byte, input item_is_text,
                  input item_end, input item_index, input parse_error, output ready);
endinterface

### design/apev2_tag_item_parser.sv
// APEv2 tag item parser: takes the item region one byte per word and returns one
// classified word per byte. The parser state advances in the cycle a byte is taken,
// so one byte is accepted every clock cycle while input ready is high; its result
// is registered in the output or skid register. A two-entry output stage (result
// register plus skid register) keeps input ready high while one result waits;
// input ready drops only while both entries are full. The user must write region
// size and item count through the cfg_ port only while the block is idle; the
// block does not enforce this. Depends on apev_pkg, apev_in_if and apev_out_if.
module apev2_tag_item_parser
  import apev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  apev_in_if.sink               in_if,
  apev_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [REGION_W-1:0] region_size_r;
  logic [INDEX_W-1:0]  item_count_r;

  // Parser state
  phase_t              phase_r, phase_nxt;
  logic [1:0]          fidx_r, fidx_nxt;
  logic [LEN_W-1:0]    vlen_r, vlen_nxt;
  logic                text_r, text_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0]    remain_r, remain_nxt;
  logic [INDEX_W-1:0]  done_r, done_nxt;
  logic                error_r, error_nxt;

  // Output stage
  logic                out_valid_r, skid_valid_r;
  result_t             out_word_r, skid_word_r;
  result_t             res;

  logic                in_fire, out_free;
  logic [BYTE_W-1:0]   b;
  logic                ignore_byte;
  logic [LEN_W+1:0]    need;
  logic [LEN_W-1:0]    remain_dec;
  logic                iend;

  assign b         = in_if.data_byte;
  assign in_if.ready = !skid_valid_r;
  assign in_fire   = in_if.valid && !skid_valid_r;
  assign out_free  = !out_valid_r || out_if.ready;

  assign ignore_byte = error_r || !(done_r < item_count_r);
  assign need = {2'b00, pos_r} + {2'b00, vlen_r} + {{(LEN_W+1){1'b0}}, 1'b1};
  assign remain_dec = (remain_r != '0) ? (remain_r - {{(LEN_W-1){1'b0}}, 1'b1}) : remain_r;

  // Classify the byte and compute next parser state
  always_comb begin
    phase_nxt  = phase_r;
    fidx_nxt   = fidx_r;
    vlen_nxt   = vlen_r;
    text_nxt   = text_r;
    pos_nxt    = pos_r;
    remain_nxt = remain_r;
    done_nxt   = done_r;
    error_nxt  = error_r;
    iend       = 1'b0;

    res.byte_class   = CL_IGN;
    res.out_byte     = b;
    res.item_is_text = 1'b0;
    res.item_end     = 1'b0;
    res.item_index   = done_r;

    if (!ignore_byte) begin
      if (pos_r >= {1'b0, region_size_r}) begin
        // region ended inside an item
        error_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            unique case (fidx_r)
              2'd0: begin
                vlen_nxt = {{(LEN_W-BYTE_W){1'b0}}, b};
                text_nxt = 1'b1;
              end
              2'd1: vlen_nxt[15:8]  = vlen_r[15:8]  | b;
              2'd2: vlen_nxt[23:16] = vlen_r[23:16] | b;
              default: vlen_nxt[31:24] = vlen_r[31:24] | b;
            endcase
            res.byte_class = CL_LEN;
            if (fidx_r == 2'd3) begin
              fidx_nxt  = 2'd0;
              phase_nxt = PH_FLAGS;
            end else begin
              fidx_nxt = fidx_r + 2'd1;
            end
          end
          PH_FLAGS: begin
            if (fidx_r == 2'd0) text_nxt = ((b & TYPE_MASK) == '0);
            res.byte_class = CL_FLAG;
            if (fidx_r == 2'd3) begin
              fidx_nxt  = 2'd0;
              phase_nxt = PH_KEY;
            end else begin
              fidx_nxt = fidx_r + 2'd1;
            end
          end
          PH_KEY: begin
            if (b == '0) begin
              res.byte_class = CL_TERM;
              if (need > {3'b000, region_size_r}) begin
                error_nxt = 1'b1;
              end else if (vlen_r == '0) begin
                iend = 1'b1;
              end else begin
                remain_nxt = vlen_r;
                phase_nxt  = PH_VALUE;
              end
            end else begin
              res.byte_class = CL_KEY;
              // fold ASCII upper case to lower case
              if (b >= 8'h41 && b <= 8'h5A) res.out_byte = b + 8'h20;
            end
          end
          default: begin
            res.byte_class = CL_VALUE;
            remain_nxt     = remain_dec;
            if (remain_dec == '0) iend = 1'b1;
          end
        endcase

        res.item_is_text = text_nxt;
        pos_nxt          = pos_r + {{(POS_W-1){1'b0}}, 1'b1};
        // close the item
        if (iend) begin
          done_nxt  = done_r + {{(INDEX_W-1){1'b0}}, 1'b1};
          phase_nxt = PH_LEN;
          fidx_nxt  = 2'd0;
        end
      end
    end

    res.item_end    = iend;
    res.parse_error = error_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_size_r <= '0;
      item_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_SIZE: region_size_r <= cfg_wdata[REGION_W-1:0];
        default:         item_count_r  <= cfg_wdata[INDEX_W-1:0];
      endcase
    end
  end

  // Advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      fidx_r   <= 2'd0;
      vlen_r   <= '0;
      text_r   <= 1'b1;
      pos_r    <= '0;
      remain_r <= '0;
      done_r   <= '0;
      error_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      fidx_r   <= fidx_nxt;
      vlen_r   <= vlen_nxt;
      text_r   <= text_nxt;
      pos_r    <= pos_nxt;
      remain_r <= remain_nxt;
      done_r   <= done_nxt;
      error_r  <= error_nxt;
    end
  end

  // Output register and skid register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output register and skid register: payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r <= skid_valid_r ? skid_word_r : res;
    end else if (in_fire) begin
      skid_word_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.byte_class   = out_word_r.byte_class;
  assign out_if.out_byte     = out_word_r.out_byte;
  assign out_if.item_is_text = out_word_r.item_is_text;
  assign out_if.item_end     = out_word_r.item_end;
  assign out_if.item_index   = out_word_r.item_index;
  assign out_if.parse_error  = out_word_r.parse_error;

endmodule
